// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Assertion that is switched off while reset is held.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALL(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/aapc_pkg.sv =====
// ----------------------------------------------------------------------------
// aapc_pkg
// Shared widths, constants and types of the all-prime array checker.
// ----------------------------------------------------------------------------
package aapc_pkg;

  // Width of one array element.
  localparam int unsigned VALUE_WIDTH = 32;

  // Trial divisor width: covers sqrt(2^(VALUE_WIDTH-1)) plus one step of two.
  localparam int unsigned DIV_W = VALUE_WIDTH / 2 + 1;

  // Running square of the divisor; may overshoot the value by one step.
  localparam int unsigned SQ_W = VALUE_WIDTH + 1;

  // Bit counter of the remainder unit, holds VALUE_WIDTH itself.
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  localparam logic [VALUE_WIDTH-1:0] VAL_TWO   = VALUE_WIDTH'(2);
  localparam logic [DIV_W-1:0]       FIRST_DIV = DIV_W'(3);
  localparam logic [SQ_W-1:0]        FIRST_SQ  = SQ_W'(9);
  localparam logic [CNT_W-1:0]       BIT_COUNT = CNT_W'(VALUE_WIDTH);

  // Status of the remainder unit toward the sequencer.
  typedef struct packed {
    logic done;  // one-cycle pulse, remainder valid
    logic zero;  // remainder is zero
  } rem_stat_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } seq_state_e;

endpackage

// ===== rtl/aapc_if.sv =====
// ----------------------------------------------------------------------------
// aapc_if
// Valid/ready channels for array elements and per-element verdicts.
// ----------------------------------------------------------------------------
interface aapc_in_if import aapc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          end_of_array;

  modport source (output valid, output value, output end_of_array, input ready);
  modport sink   (input valid, input value, input end_of_array, output ready);
endinterface

interface aapc_out_if;
  logic valid;
  logic ready;
  logic element_is_prime;
  logic all_prime_so_far;
  logic array_done;

  modport source (output valid, output element_is_prime, output all_prime_so_far,
                  output array_done, input ready);
  modport sink   (input valid, input element_is_prime, input all_prime_so_far,
                  input array_done, output ready);
endinterface

// ===== rtl/array_all_prime_check_unit.sv =====
// ----------------------------------------------------------------------------
// array_all_prime_check_unit
// Trial-division primality test per array element with a running all-prime
// verdict that re-arms after the last element.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  in_i     in   value (signed), end_of_array                     valid/ready
//  out_o    out  element_is_prime, all_prime_so_far, array_done   valid/ready
//
//  Negative, small and even values are settled on acceptance; an odd value is
//  divided in turn by each odd divisor 3, 5, 7 and so on up to its square
//  root, in the bit-serial remainder unit.
//  One element at a time: in_i.ready is high only between elements.
//  The verdict waits in an output register; a stalled out_o holds it, and a
//  finished element waits for that register to free. Reset re-arms the flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module array_all_prime_check_unit import aapc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  aapc_in_if.sink    in_i,
  aapc_out_if.source out_o
);

  seq_state_e             state_q, state_d;
  logic [VALUE_WIDTH-1:0] v_q, v_d;
  logic                   last_q, last_d;
  logic                   prime_q, prime_d;
  logic [DIV_W-1:0]       d_q, d_d;
  logic [SQ_W-1:0]        sq_q, sq_d;
  logic                   run_q, run_d;
  logic                   ovld_q, ovld_d;
  logic                   oprime_q, oprime_d;
  logic                   oall_q, oall_d;
  logic                   odone_q, odone_d;

  logic                   in_fire;
  logic                   out_free;
  logic                   rem_start;
  rem_stat_t              rem_stat;
  logic [VALUE_WIDTH-1:0] in_val;

  assign in_val   = in_i.value;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !ovld_q || out_o.ready;

  assign in_i.ready = (state_q == S_IDLE);
  assign rem_start  = (state_q == S_CHECK) && (sq_q <= {1'b0, v_q});

  aapc_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (v_q),
    .divisor_i  (d_q),
    .stat_o     (rem_stat)
  );

  always_comb begin
    state_d  = state_q;
    v_d      = v_q;
    last_d   = last_q;
    prime_d  = prime_q;
    d_d      = d_q;
    sq_d     = sq_q;
    run_d    = run_q;
    ovld_d   = ovld_q && !out_o.ready;
    oprime_d = oprime_q;
    oall_d   = oall_q;
    odone_d  = odone_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          v_d    = in_val;
          last_d = in_i.end_of_array;
          d_d    = FIRST_DIV;
          sq_d   = FIRST_SQ;
          // Settle sign, small and even values at once.
          if (in_val[VALUE_WIDTH-1] || in_val < VAL_TWO) begin
            prime_d = 1'b0;
            state_d = S_DONE;
          end else if (in_val == VAL_TWO) begin
            prime_d = 1'b1;
            state_d = S_DONE;
          end else if (!in_val[0]) begin
            prime_d = 1'b0;
            state_d = S_DONE;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (rem_start) begin
          state_d = S_DIV;
        end else begin
          // Divisor passed the square root: no factor found.
          prime_d = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            prime_d = 1'b0;
            state_d = S_DONE;
          end else begin
            // Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4.
            d_d     = d_q + DIV_W'(2);
            sq_d    = sq_q + {{(SQ_W-DIV_W-2){1'b0}}, d_q, 2'b00} + SQ_W'(4);
            state_d = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          ovld_d   = 1'b1;
          oprime_d = prime_q;
          oall_d   = run_q && prime_q;
          odone_d  = last_q;
          run_d    = last_q ? 1'b1 : (run_q && prime_q);
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      run_q   <= 1'b1;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    last_q   <= last_d;
    prime_q  <= prime_d;
    d_q      <= d_d;
    sq_q     <= sq_d;
    oprime_q <= oprime_d;
    oall_q   <= oall_d;
    odone_q  <= odone_d;
  end

  assign out_o.valid            = ovld_q;
  assign out_o.element_is_prime = oprime_q;
  assign out_o.all_prime_so_far = oall_q;
  assign out_o.array_done       = odone_q;

  `ASSERT_RST(a_div_odd, clk_i, rst_ni, (state_q == S_CHECK || state_q == S_DIV) |-> d_q[0], "even trial divisor")
  `ASSERT_RST(a_sq_track, clk_i, rst_ni, (state_q == S_CHECK) |-> (sq_q == (SQ_W'(d_q) * SQ_W'(d_q))), "divisor square out of step")
  `ASSERT_RST(a_prime_shape, clk_i, rst_ni, (state_q == S_DONE && prime_q) |-> (v_q[0] || v_q == VAL_TWO), "even value judged prime")
  `ASSERT_RST(a_hold_done, clk_i, rst_ni, (state_q == S_DONE && !out_free) |=> (state_q == S_DONE), "verdict dropped while output full")

endmodule

// ===== rtl/aapc_rem.sv =====
// ----------------------------------------------------------------------------
// aapc_rem
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aapc_rem import aapc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [DIV_W-1:0]       divisor_i,
  output rem_stat_t              stat_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] num_q, num_d;
  logic [DIV_W-1:0]       rem_q, rem_d;
  logic [DIV_W-1:0]       div_q, div_d;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;

  // Shift in the next dividend bit and subtract if it fits.
  assign trial = {rem_q, num_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = BIT_COUNT;
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[VALUE_WIDTH-2:0], 1'b0};
      rem_d = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.zero = (rem_q == '0);

  `ASSERT_RST(a_rem_below_div, clk_i, rst_ni, done_q |-> (rem_q < div_q), "remainder not below divisor")
  `ASSERT_RST(a_no_restart, clk_i, rst_ni, start_i |-> !busy_q, "start while busy")
  `ASSERT_RST(a_start_busy, clk_i, rst_ni, start_i |=> (busy_q && !done_q), "start did not launch")

endmodule
